@@ sv/cds_pkg.sv @@
// Shared types, constants and decode functions of the clock display scanner.
package cds_pkg;

  localparam int DIGITS      = 4;
  localparam int MATRIX_ROWS = 8;
  localparam int STORE_DEPTH = 4;
  localparam int NUM_TIMERS  = 4;

  localparam int PERIOD_W    = 16;
  localparam int PATTERN_W   = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  localparam int DIGIT_PTR_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int ROW_PTR_W   = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

  // Timer slots inside the countdown bank.
  localparam int T_DIGIT  = 0;
  localparam int T_BLINK  = 1;
  localparam int T_SECOND = 2;
  localparam int T_ROW    = 3;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef period_t [NUM_TIMERS-1:0] period_bank_t;
  typedef logic [3:0] bcd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIGIT_SCAN = 3'd0,
    CFG_BLINK      = 3'd1,
    CFG_SECOND     = 3'd2,
    CFG_ROW_SCAN   = 3'd3,
    CFG_PATTERN    = 3'd4
  } cfg_reg_e;

  localparam period_bank_t RESET_PERIODS = {16'd2, 16'd100, 16'd100, 16'd100};
  localparam logic [PATTERN_W-1:0] RESET_PATTERN = 64'h004242427E42423C;

  localparam logic [4:0] HOUR_RST   = 5'd15;
  localparam logic [5:0] MINUTE_RST = 6'd8;
  localparam logic [5:0] SECOND_RST = 6'd50;
  localparam bcd_t [STORE_DEPTH-1:0] STORE_RST = {4'd4, 4'd3, 4'd2, 4'd1};

  localparam logic [5:0] SEC_LIMIT  = 6'd60;
  localparam logic [5:0] MIN_LIMIT  = 6'd60;
  localparam logic [4:0] HOUR_LIMIT = 5'd24;

  // Which countdowns ran out on this item.
  typedef struct packed {
    logic row;
    logic second;
    logic blink;
    logic digit;
  } expire_t;

  // Result item; the last field sits in the lowest bits.
  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [7:0] row_columns;
    logic [7:0] row_enables;
    logic       indicator;
    logic [6:0] segments;
    logic [3:0] digit_enables;
  } result_t;

  // Lit segments of a decimal digit, bit 0 is segment a; other codes stay dark.
  function automatic logic [6:0] seg_font(input bcd_t v);
    logic [6:0] pat;
    case (v)
      4'd0:    pat = 7'b0111111;
      4'd1:    pat = 7'b0000110;
      4'd2:    pat = 7'b1011011;
      4'd3:    pat = 7'b1001111;
      4'd4:    pat = 7'b1100110;
      4'd5:    pat = 7'b1101101;
      4'd6:    pat = 7'b1111101;
      4'd7:    pat = 7'b0000111;
      4'd8:    pat = 7'b1111111;
      4'd9:    pat = 7'b1101111;
      default: pat = 7'b0000000;
    endcase
    return pat;
  endfunction

  // Tens digit of a value below sixty.
  function automatic bcd_t tens_of(input logic [5:0] v);
    bcd_t t;
    if (v >= 6'd50)      t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  function automatic bcd_t ones_of(input logic [5:0] v);
    logic [5:0] tens_x10;
    tens_x10 = 6'(tens_of(v)) * 6'd10;
    return 4'(v - tens_x10);
  endfunction

endpackage

@@ sv/cds_countdowns.sv @@
// Bank of four reload countdowns that flag expiry on each tick.
module cds_countdowns import cds_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  period_bank_t periods_i,
  output expire_t      expire_o
);

  period_bank_t cnt_q, cnt_d;
  logic [NUM_TIMERS-1:0] fire;

  always_comb begin
    cnt_d = cnt_q;
    for (int k = 0; k < NUM_TIMERS; k++) begin
      fire[k] = (cnt_q[k] <= period_t'(1));
      if (step_i) begin
        if (fire[k]) begin
          // A zero period behaves as a period of one.
          cnt_d[k] = (periods_i[k] == '0) ? period_t'(1) : periods_i[k];
        end else begin
          cnt_d[k] = cnt_q[k] - period_t'(1);
        end
      end
    end
  end

  assign expire_o.digit  = step_i & fire[T_DIGIT];
  assign expire_o.blink  = step_i & fire[T_BLINK];
  assign expire_o.second = step_i & fire[T_SECOND];
  assign expire_o.row    = step_i & fire[T_ROW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= RESET_PERIODS;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ sv/cds_clock_core.sv @@
// Time of day, digit store, digit and row scanners and the indicator level.
module cds_clock_core import cds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  expire_t              expire_i,
  input  logic [PATTERN_W-1:0] pattern_i,
  output result_t              next_o
);

  logic [4:0] hour_q, hour_d;
  logic [5:0] minute_q, minute_d;
  logic [5:0] second_q, second_d;
  bcd_t [STORE_DEPTH-1:0] store_q, store_d;
  logic [DIGIT_PTR_W-1:0] dptr_q, dptr_d;
  logic [ROW_PTR_W-1:0]   rptr_q, rptr_d;
  logic [3:0] digits_q, digits_d;
  logic [6:0] segs_q, segs_d;
  logic       ind_q, ind_d;
  logic [7:0] rows_q, rows_d;
  logic [7:0] cols_q, cols_d;

  logic [5:0] sec_inc, min_inc;
  logic [4:0] hour_inc;
  logic       sec_wrap, min_wrap;
  bcd_t       cur_digit;
  logic [7:0] row_byte;

  // Clock advance: the wraps cascade from seconds up to hours.
  always_comb begin
    sec_inc  = second_q + 6'd1;
    sec_wrap = (sec_inc >= SEC_LIMIT);
    min_inc  = minute_q + (sec_wrap ? 6'd1 : 6'd0);
    min_wrap = (min_inc >= MIN_LIMIT);
    hour_inc = hour_q + (min_wrap ? 5'd1 : 5'd0);

    second_d = second_q;
    minute_d = minute_q;
    hour_d   = hour_q;
    store_d  = store_q;
    if (expire_i.second) begin
      second_d   = sec_wrap ? 6'd0 : sec_inc;
      minute_d   = min_wrap ? 6'd0 : min_inc;
      hour_d     = (hour_inc >= HOUR_LIMIT) ? 5'd0 : hour_inc;
      store_d[0] = tens_of(6'(hour_d));
      store_d[1] = ones_of(6'(hour_d));
      store_d[2] = tens_of(minute_d);
      store_d[3] = ones_of(minute_d);
    end
  end

  // Digit scan reads the store as it was before this item's clock advance.
  always_comb begin
    cur_digit = store_q[STORE_IDX_W'(dptr_q)];
    digits_d  = digits_q;
    segs_d    = segs_q;
    dptr_d    = dptr_q;
    if (expire_i.digit) begin
      if (32'(dptr_q) < STORE_DEPTH) begin
        digits_d = ~(4'd1 << dptr_q);
        segs_d   = ~seg_font(cur_digit);
      end else begin
        digits_d = '1;
        segs_d   = '1;
      end
      dptr_d = (dptr_q == DIGIT_PTR_W'(DIGITS - 1)) ? '0 : dptr_q + 1'b1;
    end
  end

  always_comb begin
    row_byte = 8'(pattern_i >> {rptr_q, 3'b000});
    rows_d   = rows_q;
    cols_d   = cols_q;
    rptr_d   = rptr_q;
    if (expire_i.row) begin
      rows_d = ~(8'd1 << rptr_q);
      cols_d = ~row_byte;
      rptr_d = (rptr_q == ROW_PTR_W'(MATRIX_ROWS - 1)) ? '0 : rptr_q + 1'b1;
    end
  end

  assign ind_d = ind_q ^ expire_i.blink;

  always_comb begin
    next_o.digit_enables = digits_d;
    next_o.segments      = segs_d;
    next_o.indicator     = ind_d;
    next_o.row_enables   = rows_d;
    next_o.row_columns   = cols_d;
    next_o.hours         = hour_d;
    next_o.minutes       = minute_d;
    next_o.seconds       = second_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q   <= HOUR_RST;
      minute_q <= MINUTE_RST;
      second_q <= SECOND_RST;
      store_q  <= STORE_RST;
      dptr_q   <= '0;
      rptr_q   <= '0;
      digits_q <= '0;
      segs_q   <= '0;
      ind_q    <= 1'b1;
      rows_q   <= '0;
      cols_q   <= '0;
    end else begin
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      store_q  <= store_d;
      dptr_q   <= dptr_d;
      rptr_q   <= rptr_d;
      digits_q <= digits_d;
      segs_q   <= segs_d;
      ind_q    <= ind_d;
      rows_q   <= rows_d;
      cols_q   <= cols_d;
    end
  end

endmodule

@@ sv/clock_display_scanner.sv @@
// Top level of the multiplexed seven-segment clock with LED matrix scanner.
//
//   Channel  Direction  Payload                                     Handshake
//   s_axis   in         tdata[0] tick, [7:1] zero                   tvalid/tready
//   m_axis   out        tdata[44:0] display and time fields         tvalid/tready
//   cfg      in         cfg_index_i selects period or pattern       cfg_we_i, no wait
//
// An item passes an input register and then a result register; one item can be accepted
// every cycle while the output is not stalled.
// The countdowns, clock and scanners update when the item leaves the input register.
// Reset loads the default periods and pattern and the time 15:08:50.
// While the result register is stalled, the input register still takes one item.
module clock_display_scanner import cds_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [0] tick, [7:1] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [3:0] digit_enables, [10:4] segments, [11] indicator, [19:12] row_enables,
  // [27:20] row_columns, [32:28] hours, [38:33] minutes, [44:39] seconds, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [PATTERN_W-1:0]   cfg_wdata_i
);

  period_bank_t         periods_q;
  logic [PATTERN_W-1:0] pattern_q;

  logic    in_valid_q, in_tick_q;
  logic    out_valid_q;
  result_t res_q;
  logic    in_accept, advance;
  expire_t expire;
  result_t res_next;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periods_q <= RESET_PERIODS;
      pattern_q <= RESET_PATTERN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DIGIT_SCAN: periods_q[T_DIGIT]  <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_BLINK:      periods_q[T_BLINK]  <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_SECOND:     periods_q[T_SECOND] <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_ROW_SCAN:   periods_q[T_ROW]    <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_PATTERN:    pattern_q           <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  cds_countdowns u_countdowns (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance && in_tick_q),
    .periods_i (periods_q),
    .expire_o  (expire)
  );

  cds_clock_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .expire_i  (expire),
    .pattern_i (pattern_q),
    .next_o    (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_tick_q <= s_axis_tdata_i[0];
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - $bits(result_t))'(0), res_q};

`ifndef NO_ASSERTIONS
  // The displayed time never leaves its range.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.hours < HOUR_LIMIT) && (res_q.minutes < MIN_LIMIT) &&
                    (res_q.seconds < SEC_LIMIT))
    else $error("time field out of range");

  // A held input item keeps its tick until it moves on.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_tick_q))
    else $error("input register lost a stalled item");

  // With both registers full and the output stalled, no item may enter.
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("item accepted while pipeline full");

  // Countdowns only expire on a tick that moves into the result register.
  a_expire_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (expire.digit || expire.blink || expire.second || expire.row) |-> advance && in_tick_q)
    else $error("countdown expired without a tick");
`endif

endmodule

@@ dv/tb_clock_display_scanner.sv @@
// Self-checking testbench of the clock display scanner: a tick model checks every result.
module tb_clock_display_scanner;
  import cds_pkg::*;

  localparam int CYCLE_LIMIT      = 100_000;
  localparam int DRAIN_CYCLES     = 4;
  localparam int FAST_CLOCK_TICKS = 400;
  localparam int PHASE_ITEMS      = 75;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = CFG_IDX_W'(CFG_PATTERN + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST  = '1;
  localparam logic [6:0] DIGIT_LIT [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // [0] tick, [7:1] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // [3:0] digit_enables, [10:4] segments, [11] indicator, [19:12] row_enables,
  // [27:20] row_columns, [32:28] hours, [38:33] minutes, [44:39] seconds
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [PATTERN_W-1:0]   cfg_wdata_i = '0;

  clock_display_scanner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model of the clock, the scanners and the countdown bank.
  period_t               tick_period [NUM_TIMERS];
  period_t               ticks_left  [NUM_TIMERS];
  logic [PATTERN_W-1:0]  image_rows;
  logic [4:0]            hour_now;
  logic [5:0]            minute_now;
  logic [5:0]            second_now;
  bcd_t                  shown_digit [STORE_DEPTH];
  logic [DIGIT_PTR_W-1:0] digit_sel;
  logic [ROW_PTR_W-1:0]  row_sel;
  result_t               pins;

  result_t pending_displays [$];

  int errors         = 0;
  int items_sent     = 0;
  int ticks_sent     = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  int minute_carries = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  task automatic model_reset();
    tick_period[T_DIGIT]  = 16'd100;
    tick_period[T_BLINK]  = 16'd100;
    tick_period[T_SECOND] = 16'd100;
    tick_period[T_ROW]    = 16'd2;
    for (int k = 0; k < NUM_TIMERS; k++) ticks_left[k] = tick_period[k];
    image_rows = 64'h004242427E42423C;
    hour_now   = 5'd15;
    minute_now = 6'd8;
    second_now = 6'd50;
    for (int d = 0; d < STORE_DEPTH; d++) shown_digit[d] = bcd_t'(d + 1);
    digit_sel = '0;
    row_sel   = '0;
    pins      = '0;
    pins.indicator = 1'b1;
  endtask

  // Applies one tick item to the model and returns the pin levels after it.
  task automatic step_clock_model(input logic tick, output result_t levels);
    logic [NUM_TIMERS-1:0] fired;
    bcd_t                  v;
    int                    r;
    fired = '0;
    if (tick) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
        if (ticks_left[k] <= 1) begin
          ticks_left[k] = (tick_period[k] == 0) ? period_t'(1) : tick_period[k];
          fired[k] = 1'b1;
        end else begin
          ticks_left[k] = ticks_left[k] - 1'b1;
        end
      end
      // The digit scan sees the store as it was before this tick's clock advance.
      if (fired[T_DIGIT]) begin
        if (int'(digit_sel) < DIGITS) begin
          v = shown_digit[digit_sel];
          pins.digit_enables = ~(4'b0001 << digit_sel);
          pins.segments = (v < 10) ? ~DIGIT_LIT[v] : 7'h7F;
        end else begin
          pins.digit_enables = 4'hF;
          pins.segments = 7'h7F;
        end
        digit_sel = DIGIT_PTR_W'((int'(digit_sel) + 1) % DIGITS);
      end
      if (fired[T_BLINK]) pins.indicator = ~pins.indicator;
      if (fired[T_SECOND]) begin
        second_now++;
        if (second_now >= 6'd60) begin
          second_now = '0;
          minute_now++;
          minute_carries++;
        end
        if (minute_now >= 6'd60) begin
          minute_now = '0;
          hour_now++;
        end
        if (hour_now >= 5'd24) begin
          hour_now = '0;
        end
        shown_digit[0] = bcd_t'(hour_now / 10);
        shown_digit[1] = bcd_t'(hour_now % 10);
        shown_digit[2] = bcd_t'(minute_now / 10);
        shown_digit[3] = bcd_t'(minute_now % 10);
      end
      if (fired[T_ROW]) begin
        r = int'(row_sel);
        pins.row_enables = ~(8'b1 << r);
        pins.row_columns = ~image_rows[8*r +: 8];
        row_sel = ROW_PTR_W'((r + 1) % MATRIX_ROWS);
      end
    end
    pins.hours   = hour_now;
    pins.minutes = minute_now;
    pins.seconds = second_now;
    levels = pins;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0d] mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
             cycle_count, what, results_seen, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_displays.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);
      if (pending_displays.size() == 0) begin
        report_mismatch("unexpected result", 64'(m_axis_tdata_o), '0);
      end else begin
        want = pending_displays.pop_front();
        check_field("digit_enables", 64'(got.digit_enables), 64'(want.digit_enables));
        check_field("segments", 64'(got.segments), 64'(want.segments));
        check_field("indicator", 64'(got.indicator), 64'(want.indicator));
        check_field("row_enables", 64'(got.row_enables), 64'(want.row_enables));
        check_field("row_columns", 64'(got.row_columns), 64'(want.row_columns));
        check_field("hours", 64'(got.hours), 64'(want.hours));
        check_field("minutes", 64'(got.minutes), 64'(want.minutes));
        check_field("seconds", 64'(got.seconds), 64'(want.seconds));
      end
      results_seen++;
    end
  end

  task automatic send_tick(input logic tick);
    result_t levels;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_TDATA_W-1){1'b0}}, tick};
    do @(posedge clk_i); while (!s_axis_tready_o);
    step_clock_model(tick, levels);
    pending_displays.push_back(levels);
    items_sent++;
    if (tick) ticks_sent++;
  endtask

  // Lets every outstanding result arrive, then a few cycles more.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PATTERN_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DIGIT_SCAN: tick_period[T_DIGIT]  = val[PERIOD_W-1:0];
      CFG_BLINK:      tick_period[T_BLINK]  = val[PERIOD_W-1:0];
      CFG_SECOND:     tick_period[T_SECOND] = val[PERIOD_W-1:0];
      CFG_ROW_SCAN:   tick_period[T_ROW]    = val[PERIOD_W-1:0];
      CFG_PATTERN:    image_rows = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic period_t pick_period();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (sel < 80) return period_t'($urandom_range(1, 6));
    return period_t'($urandom_range(7, 40));
  endfunction

  function automatic logic [PATTERN_W-1:0] pick_pattern();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return '1;
    return {$urandom, $urandom};
  endfunction

  // Items without a tick right after reset, the first row scan, pattern extremes, ignored indexes.
  task automatic test_reset_and_hold();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_results();
    write_reg(CFG_PATTERN, '1);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_results();
    write_reg(CFG_PATTERN, '0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_results();
    for (int i = CFG_UNUSED_FIRST; i <= CFG_UNUSED_LAST; i++) write_reg(CFG_IDX_W'(i), '1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_results();
  endtask

  // New periods only take effect once the running countdowns reload; zero acts as one.
  task automatic test_period_change();
    write_reg(CFG_DIGIT_SCAN, '0);
    write_reg(CFG_BLINK, 64'd1);
    write_reg(CFG_SECOND, 64'd3);
    write_reg(CFG_ROW_SCAN, 64'd5);
    write_reg(CFG_PATTERN, 64'h8001_4002_2004_1008);
    for (int i = 0; i < 110; i++) send_tick(1'b1);
    drain_results();
  endtask

  // One second per tick across several minute boundaries.
  task automatic test_fast_clock();
    write_reg(CFG_DIGIT_SCAN, 64'd1);
    write_reg(CFG_BLINK, 64'd2);
    write_reg(CFG_SECOND, 64'd1);
    write_reg(CFG_ROW_SCAN, 64'd1);
    for (int i = 0; i < 8; i++) send_tick(1'b1);
    for (int i = 0; i < FAST_CLOCK_TICKS; i++) send_tick(1'b1);
    drain_results();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(66, 0);
        2: set_idling(0, 66);
        default: set_idling(18, 18);
      endcase
      drain_results();
      write_reg(CFG_DIGIT_SCAN, 64'(pick_period()));
      write_reg(CFG_BLINK, 64'(pick_period()));
      write_reg(CFG_SECOND, 64'(pick_period()));
      write_reg(CFG_ROW_SCAN, 64'(pick_period()));
      write_reg(CFG_PATTERN, pick_pattern());
      write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                {$urandom, $urandom});
      for (int i = 0; i < PHASE_ITEMS; i++) send_tick($urandom_range(99) < 85);
    end
    set_idling(0, 0);
    drain_results();
  endtask

  // Longest periods: each countdown reloads once with 65535 and then holds.
  task automatic test_long_periods();
    set_idling(18, 18);
    write_reg(CFG_DIGIT_SCAN, 64'hFFFF);
    write_reg(CFG_BLINK, 64'hFFFF);
    write_reg(CFG_SECOND, 64'hFFFF);
    write_reg(CFG_ROW_SCAN, 64'hFFFF);
    write_reg(CFG_PATTERN, {$urandom, $urandom});
    for (int i = 0; i < 60; i++) send_tick($urandom_range(99) < 85);
    set_idling(0, 0);
    drain_results();
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_and_hold();
    test_period_change();
    test_fast_clock();
    test_random_phases();
    test_long_periods();
    repeat (2 * DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d items (%0d ticks), compared %0d results, %0d register writes.",
             items_sent, ticks_sent, results_seen, reg_writes);
    $display("Seconds carried into minutes %0d time(s) under idle, stall and mixed traffic.",
             minute_carries);
    if (pending_displays.size() != 0) begin
      $display("%0d expected results never arrived", pending_displays.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
